@@ design/sorted_char_list_engine_macros.svh @@
// Assertion helpers for the sorted character list engine.
`ifndef SORTED_CHAR_LIST_ENGINE_MACROS_SVH
`define SORTED_CHAR_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, reset masked.
`define SCLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scle check failed");

// Next-cycle implication, reset masked.
`define SCLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scle check failed");

`endif

@@ design/scle_pkg.sv @@
package scle_pkg;

  localparam int LIST_DEPTH = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_ELEMENT   = 3'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic              list_select;
    logic signed [7:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic signed [7:0] element;
    logic              last;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_MARK,
    OP_ROTATE
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_STREAM
  } state_t;

  // Command broadcast to every cell.
  typedef struct packed {
    op_t               op;
    logic              sel;
    logic signed [7:0] value;
  } cmd_t;

  // What a cell shows its neighbors for the selected list.
  typedef struct packed {
    logic signed [7:0] data;
    logic              occ;
    logic              tag;
    logic              stay;
  } link_t;

endpackage

@@ design/scle_cell.sv @@
module scle_cell
  import scle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic              is_head,
  input  link_t             left_lnk,
  input  link_t             right_lnk,
  input  logic signed [7:0] head_data,
  input  logic              head_tag,
  output link_t             lnk
);

  logic signed [7:0] data_r   [2];
  logic signed [7:0] data_nxt [2];
  logic [1:0]        occ_r;
  logic [1:0]        occ_nxt;
  logic              tag_r;
  logic              tag_nxt;

  always_comb begin
    lnk.data = data_r[cmd.sel];
    lnk.occ  = occ_r[cmd.sel];
    lnk.tag  = tag_r;
    // elements below the value stay put on insert and delete
    lnk.stay = occ_r[cmd.sel] && (data_r[cmd.sel] < cmd.value);
  end

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    tag_nxt  = tag_r;
    case (cmd.op)
      OP_INSERT: begin
        if (!lnk.stay) begin
          data_nxt[cmd.sel] = left_lnk.stay ? cmd.value : left_lnk.data;
        end
        occ_nxt[cmd.sel] = occ_r[cmd.sel] | left_lnk.occ;
      end
      OP_DELETE: begin
        if (!lnk.stay) begin
          data_nxt[cmd.sel] = right_lnk.data;
          occ_nxt[cmd.sel]  = right_lnk.occ;
        end
      end
      OP_MARK: begin
        tag_nxt = is_head;
      end
      OP_ROTATE: begin
        if (right_lnk.occ) begin
          data_nxt[cmd.sel] = right_lnk.data;
          tag_nxt           = right_lnk.tag;
        end else begin
          data_nxt[cmd.sel] = head_data;
          tag_nxt           = head_tag;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      occ_r <= '0;
      tag_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      tag_r <= tag_nxt;
    end
  end

endmodule

@@ design/sorted_char_list_engine.sv @@
// Insert and delete: decided in the exec state, result word registered; a new start is taken once busy drops.
// Read out: the exec state marks the head, then one element word per cycle until the last element.
// Every request is decided by one pass over the cell chain; read out rotates the chain once.
// Results are registered and shown for one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties both lists; stored characters are not cleared.
`include "sorted_char_list_engine_macros.svh"

module sorted_char_list_engine
  import scle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  // Request register, control state and the result register.
  in_word_t  req_r;
  state_t    state_r;
  state_t    state_nxt;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t out_word_r;
  out_word_t out_word_nxt;

  cmd_t  cmd;
  link_t lnk      [LIST_DEPTH];
  link_t left_of  [LIST_DEPTH];
  link_t right_of [LIST_DEPTH];
  link_t second_lnk;

  logic [LIST_DEPTH-1:0] occ_v;
  logic [LIST_DEPTH-1:0] match_v;
  logic                  found;

  // Chain ends: before the head every element "stays" so an insert lands at
  // the first cell that does not; past the tail nothing is occupied.
  localparam link_t LEFT_END  = '{data: 8'sd0, occ: 1'b1, tag: 1'b0, stay: 1'b1};
  localparam link_t RIGHT_END = '{data: 8'sd0, occ: 1'b0, tag: 1'b0, stay: 1'b0};

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_l
        assign left_of[gi] = LEFT_END;
      end else begin : g_l
        assign left_of[gi] = lnk[gi-1];
      end
      if (gi == LIST_DEPTH - 1) begin : g_r
        assign right_of[gi] = RIGHT_END;
      end else begin : g_r
        assign right_of[gi] = lnk[gi+1];
      end

      assign occ_v[gi] = lnk[gi].occ;
      // first equal element: equal here, everything to the left is smaller
      assign match_v[gi] = lnk[gi].occ && (lnk[gi].data == req_r.value) && left_of[gi].stay;

      scle_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .is_head   (gi == 0),
        .left_lnk  (left_of[gi]),
        .right_lnk (right_of[gi]),
        .head_data (lnk[0].data),
        .head_tag  (lnk[0].tag),
        .lnk       (lnk[gi])
      );
    end
  endgenerate

  assign second_lnk = right_of[0];
  assign found      = |match_v;

  // Next state, the command for the chain, and the next result word.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '{status: ST_INSERTED, element: 8'sd0, last: 1'b1};
    cmd.op        = OP_HOLD;
    cmd.sel       = req_r.list_select;
    cmd.value     = req_r.value;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (req_r.mode)
          MODE_INSERT: begin
            out_valid_nxt = 1'b1;
            if (occ_v[LIST_DEPTH-1]) begin
              out_word_nxt.status = ST_FULL;
            end else begin
              cmd.op              = OP_INSERT;
              out_word_nxt.status = ST_INSERTED;
            end
          end
          MODE_DELETE: begin
            out_valid_nxt = 1'b1;
            if (!occ_v[0]) begin
              out_word_nxt.status = ST_EMPTY;
            end else if (found) begin
              cmd.op              = OP_DELETE;
              out_word_nxt.status = ST_DELETED;
            end else begin
              out_word_nxt.status = ST_NOT_FOUND;
            end
          end
          MODE_READ: begin
            if (!occ_v[0]) begin
              out_valid_nxt       = 1'b1;
              out_word_nxt.status = ST_EMPTY;
            end else begin
              // tag the head so the stream knows when it has gone around
              cmd.op    = OP_MARK;
              state_nxt = S_STREAM;
            end
          end
          default: begin
            // unused mode: drop the request, no word
          end
        endcase
      end
      S_STREAM: begin
        cmd.op               = OP_ROTATE;
        out_valid_nxt        = 1'b1;
        out_word_nxt.status  = ST_ELEMENT;
        out_word_nxt.element = lnk[0].data;
        // last when the next head would be the tagged first element again
        out_word_nxt.last    = !second_lnk.occ || second_lnk.tag;
        if (out_word_nxt.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request for the whole operation; the result word needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
    end else if (start && !busy) begin
      req_r <= in_word;
    end
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Occupied cells of the selected list always form a prefix of the chain.
  `SCLE_ASSERT_NOW(a_occ_prefix, 1'b1, ((occ_v + 1'b1) & occ_v) == '0)
  // The closing word of a request appears only once the block is free again.
  `SCLE_ASSERT_NOW(a_last_idle, out_valid && out_word.last, state_r == S_IDLE)
  // No word in the cycle after a request is taken.
  `SCLE_ASSERT_NEXT(a_no_early_word, start && !busy, !out_valid)
  // The block reports busy for the whole stream.
  `SCLE_ASSERT_NOW(a_stream_busy, state_r == S_STREAM, busy)

endmodule
